// File: sv/asf_pkg.sv
// Shared types, constants and table functions of the averaged sample ASCII framer.
// Used by asf_cmp_sub, asf_frame_seq and averaged_sample_ascii_framer_core.
`timescale 1ns / 1ps
package asf_pkg;

  localparam int OVERSAMPLE_COUNT_DEF = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W = 16;
  localparam int NUM_W = 32;
  localparam int RATE_W = 8;
  localparam int CHAR_W = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int ITEM_W = 4;
  localparam int POW_W = 4;
  localparam int DIGIT_W = 4;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  localparam logic [RATE_W-1:0] RATE_RESET = 8'd20;
  localparam logic [RATE_W-1:0] RATE_MIN = 8'd1;
  localparam logic [RATE_W-1:0] RATE_MAX = 8'd200;

  // Register index, taken from paddr[2].
  localparam logic REG_RATE = 1'b0;

  // Places in the frame "$IR,<seq>,<avg>,<rate>*HH\n".
  localparam logic [ITEM_W-1:0] ITEM_SEQ    = 4'd4;
  localparam logic [ITEM_W-1:0] ITEM_AVG    = 4'd6;
  localparam logic [ITEM_W-1:0] ITEM_RATE   = 4'd8;
  localparam logic [ITEM_W-1:0] ITEM_STAR   = 4'd9;
  localparam logic [ITEM_W-1:0] ITEM_HEX_HI = 4'd10;
  localparam logic [ITEM_W-1:0] ITEM_HEX_LO = 4'd11;
  localparam logic [ITEM_W-1:0] ITEM_LAST   = 4'd12;

  localparam logic [POW_W-1:0] POW_TOP = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_HEX_BIAS = 8'h37;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [2:0] {
    KIND_LIT,
    KIND_SEQ,
    KIND_AVG,
    KIND_RATE,
    KIND_HEX_HI,
    KIND_HEX_LO
  } kind_e;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  seq;
    logic [SUM_W-1:0]  sum;
    logic [RATE_W-1:0] rate;
  } frame_req_t;

  function automatic kind_e item_kind(logic [ITEM_W-1:0] idx);
    kind_e k;
    case (idx)
      ITEM_SEQ:    k = KIND_SEQ;
      ITEM_AVG:    k = KIND_AVG;
      ITEM_RATE:   k = KIND_RATE;
      ITEM_HEX_HI: k = KIND_HEX_HI;
      ITEM_HEX_LO: k = KIND_HEX_LO;
      default:     k = KIND_LIT;
    endcase
    return k;
  endfunction

  function automatic char_t item_char(logic [ITEM_W-1:0] idx);
    char_t c;
    case (idx)
      4'd0:      c = "$";
      4'd1:      c = "I";
      4'd2:      c = "R";
      4'd3:      c = ",";
      4'd5:      c = ",";
      4'd7:      c = ",";
      ITEM_STAR: c = "*";
      ITEM_LAST: c = CHAR_NL;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters strictly between the dollar sign and the star feed the checksum.
  function automatic logic item_in_payload(logic [ITEM_W-1:0] idx);
    return (idx != 4'd0) && (idx < ITEM_STAR);
  endfunction

  function automatic logic [NUM_W-1:0] pow10(logic [POW_W-1:0] p);
    logic [NUM_W-1:0] v;
    case (p)
      4'd0:    v = 32'd1;
      4'd1:    v = 32'd10;
      4'd2:    v = 32'd100;
      4'd3:    v = 32'd1000;
      4'd4:    v = 32'd10000;
      4'd5:    v = 32'd100000;
      4'd6:    v = 32'd1000000;
      4'd7:    v = 32'd10000000;
      4'd8:    v = 32'd100000000;
      4'd9:    v = 32'd1000000000;
      default: v = 32'd1;
    endcase
    return v;
  endfunction

  function automatic char_t hex_char(logic [3:0] n);
    return (n < 4'd10) ? (CHAR_ZERO + {4'h0, n}) : (CHAR_HEX_BIAS + {4'h0, n});
  endfunction

endpackage

// File: sv/asf_cmp_sub.sv
// Shared compare and subtract unit of the framer sequencer.
// Depends on asf_pkg for the operand width.
`timescale 1ns / 1ps
module asf_cmp_sub (
  input  logic [asf_pkg::NUM_W-1:0] a_i,
  input  logic [asf_pkg::NUM_W-1:0] b_i,
  output logic                      ge_o,
  output logic [asf_pkg::NUM_W-1:0] diff_o
);
  import asf_pkg::*;

  logic [NUM_W:0] wide;

  // The borrow out of the extended subtraction tells whether a is below b.
  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~wide[NUM_W];
  assign diff_o = wide[NUM_W-1:0];

endmodule

// File: sv/asf_frame_seq.sv
// Frame sequencer: divides the group sum, converts numbers to decimal and emits the frame.
// Depends on asf_pkg and asf_cmp_sub.
`timescale 1ns / 1ps
module asf_frame_seq #(
  parameter int OVERSAMPLE_COUNT = asf_pkg::OVERSAMPLE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  asf_pkg::frame_req_t        req_i,
  output logic                       busy_o,
  output logic                       frame_valid_o,
  input  logic                       frame_stall_i,
  output logic [asf_pkg::CHAR_W-1:0] frame_byte_o,
  output logic                       last_o
);
  import asf_pkg::*;

  // Truncated division by the group size as a multiplication by a rounded-up
  // reciprocal. With the shift set to the sum width plus the rounded-up log2 of the
  // group size, the product is exact for every sum that fits in SUM_W bits.
  localparam int DivL = $clog2(OVERSAMPLE_COUNT);
  localparam int DivS = SUM_W + DivL;
  localparam int MulW = SUM_W + 1;
  localparam int ProdW = SUM_W + MulW;
  localparam logic [MulW-1:0] DivM =
    MulW'(((64'd1 << DivS) + 64'(OVERSAMPLE_COUNT) - 64'd1) / 64'(OVERSAMPLE_COUNT));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_NEXT  = 3'd2;
  localparam logic [2:0] ST_LIT   = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;
  localparam logic [2:0] ST_PUTD  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [NUM_W-1:0]   seq_q, seq_d;
  logic [RATE_W-1:0]  rate_q, rate_d;
  logic [SUM_W-1:0]   quo_q, quo_d;
  logic [ITEM_W-1:0]  idx_q, idx_d;
  logic [NUM_W-1:0]   val_q, val_d;
  logic [POW_W-1:0]   pidx_q, pidx_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               started_q, started_d;
  logic [CHAR_W-1:0]  xor_q, xor_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_byte_q, out_byte_d;
  logic               out_last_q, out_last_d;

  logic [ProdW-1:0]   avg_prod;
  logic [NUM_W-1:0]   unit_a, unit_b, unit_diff;
  logic               unit_ge;
  logic               can_push;
  logic               push;
  logic               push_payload;
  char_t              push_char;
  kind_e              kind;
  char_t              lit_char;

  assign avg_prod = {{MulW{1'b0}}, quo_q} * {{SUM_W{1'b0}}, DivM};
  assign kind     = item_kind(idx_q);
  assign can_push = ~out_valid_q | ~frame_stall_i;

  always_comb begin
    case (kind)
      KIND_HEX_HI: lit_char = hex_char(xor_q[7:4]);
      KIND_HEX_LO: lit_char = hex_char(xor_q[3:0]);
      default:     lit_char = item_char(idx_q);
    endcase
  end

  // The unit peels decimal digits off the value by repeated subtraction of a power of ten.
  assign unit_a = val_q;
  assign unit_b = pow10(pidx_q);

  asf_cmp_sub u_cmp_sub (
    .a_i    (unit_a),
    .b_i    (unit_b),
    .ge_o   (unit_ge),
    .diff_o (unit_diff)
  );

  always_comb begin
    state_d      = state_q;
    seq_d        = seq_q;
    rate_d       = rate_q;
    quo_d        = quo_q;
    idx_d        = idx_q;
    val_d        = val_q;
    pidx_d       = pidx_q;
    digit_d      = digit_q;
    started_d    = started_q;
    push         = 1'b0;
    push_payload = 1'b0;
    push_char    = lit_char;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          seq_d   = req_i.seq;
          rate_d  = req_i.rate;
          quo_d   = req_i.sum;
          idx_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d   = SUM_W'(avg_prod >> DivS);
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        pidx_d    = POW_TOP;
        digit_d   = '0;
        started_d = 1'b0;
        case (kind)
          KIND_SEQ: begin
            val_d   = seq_q;
            state_d = ST_DIGIT;
          end
          KIND_AVG: begin
            val_d   = NUM_W'(quo_q);
            state_d = ST_DIGIT;
          end
          KIND_RATE: begin
            val_d   = NUM_W'(rate_q);
            state_d = ST_DIGIT;
          end
          default: state_d = ST_LIT;
        endcase
      end
      ST_LIT: begin
        if (can_push) begin
          push         = 1'b1;
          push_payload = item_in_payload(idx_q);
          if (idx_q == ITEM_LAST) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_NEXT;
          end
        end
      end
      ST_DIGIT: begin
        if (unit_ge) begin
          val_d   = unit_diff;
          digit_d = digit_q + 1'b1;
        end else if ((digit_q != '0) || started_q || (pidx_q == '0)) begin
          state_d = ST_PUTD;
        end else begin
          pidx_d = pidx_q - 1'b1;
        end
      end
      ST_PUTD: begin
        push_char = CHAR_ZERO + {4'h0, digit_q};
        if (can_push) begin
          push         = 1'b1;
          push_payload = 1'b1;
          started_d    = 1'b1;
          digit_d      = '0;
          if (pidx_q == '0) begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_NEXT;
          end else begin
            pidx_d  = pidx_q - 1'b1;
            state_d = ST_DIGIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    xor_d       = (state_q == ST_IDLE) ? '0 : xor_q;
    if (out_valid_q && !frame_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (push) begin
      out_valid_d = 1'b1;
      out_byte_d  = push_char;
      out_last_d  = (state_q == ST_LIT) && (idx_q == ITEM_LAST);
      if (push_payload) begin
        xor_d = xor_q ^ push_char;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    rate_q     <= rate_d;
    quo_q      <= quo_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    pidx_q     <= pidx_d;
    digit_q    <= digit_d;
    started_q  <= started_d;
    xor_q      <= xor_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign frame_valid_o = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign last_o        = out_last_q;

  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_byte_q == CHAR_NL))
    else $error("frame end flag on a byte other than the newline");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> ((pidx_q <= POW_TOP) && (digit_q <= DIGIT_MAX)))
    else $error("decimal digit or power index out of range");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (state_q == ST_LIT) && (idx_q == ITEM_LAST)) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after the newline");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == ST_IDLE))
    else $error("frame start requested while a frame is in progress");

endmodule

// File: sv/averaged_sample_ascii_framer_core.sv
// Top level of the averaged sample ASCII framer: configuration port, sample accumulator
// and frame sequencer. Depends on asf_pkg, asf_frame_seq and asf_cmp_sub.
`timescale 1ns / 1ps
// Usage
// The sample channel (sample_valid_i, sample_stall_o, sample_i) takes one converter
// reading per word. Readings are summed; every OVERSAMPLE_COUNT words the group is
// closed, the sequence number is advanced and the frame "$IR,<seq>,<avg>,<rate>*HH"
// with a closing newline is sent on the frame channel (frame_valid_o, frame_stall_i,
// frame_byte_o, last_o), one character per word, last_o marking the newline.
// A word that does not close a group is taken whenever the sequencer is idle. The closing
// word starts the sequencer: it first scales the group sum by a constant reciprocal to
// give the truncated average, then sends each fixed character and prints each number
// digit by digit, peeling every decimal position with the single compare and subtract
// unit, one subtraction per unit of that digit. sample_stall_o is high while a frame is
// in progress.
// A stall on the frame channel simply holds the output register and the sequencer
// waits for it. The sample channel opens again once the newline is in that register.
// Reset clears the sum, the group count and the sequence number and sets the rate
// register to 20. The rate register (address 0) accepts only values 1 to 200.
module averaged_sample_ascii_framer_core #(
  parameter int OVERSAMPLE_COUNT = asf_pkg::OVERSAMPLE_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_stall_o,
  input  logic [asf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         frame_valid_o,
  input  logic                         frame_stall_i,
  output logic [asf_pkg::CHAR_W-1:0]   frame_byte_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [asf_pkg::ADDR_W-1:0]   paddr,
  input  logic [asf_pkg::DATA_W-1:0]   pwdata,
  output logic [asf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import asf_pkg::*;

  localparam int CntW = $clog2(OVERSAMPLE_COUNT + 1);

  logic [RATE_W-1:0] rate_q, rate_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NUM_W-1:0]  frame_count_q, frame_count_d;

  logic              cfg_write;
  logic [RATE_W-1:0] wr_rate;
  logic              accept;
  logic              group_done;
  logic [SUM_W-1:0]  sum_next;
  logic [NUM_W-1:0]  seq_next;
  logic              busy;
  frame_req_t        req;

  // APB: the write completes in the access phase; pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign wr_rate   = pwdata[RATE_W-1:0];

  always_comb begin
    rate_d = rate_q;
    if (cfg_write && (paddr[2] == REG_RATE) && (wr_rate >= RATE_MIN) &&
        (wr_rate <= RATE_MAX)) begin
      rate_d = wr_rate;
    end
  end

  assign prdata = (paddr[2] == REG_RATE) ? DATA_W'(rate_q) : '0;

  // Sample accumulation. The sum is sized so that a full group of readings never wraps.
  assign accept     = sample_valid_i && !sample_stall_o;
  assign group_done = (cnt_q == CntW'(OVERSAMPLE_COUNT - 1));
  assign sum_next   = sum_q + SUM_W'(sample_i & SAMPLE_MASK);
  assign seq_next   = frame_count_q + 1'b1;

  always_comb begin
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    frame_count_d = frame_count_q;
    if (accept) begin
      if (group_done) begin
        sum_d         = '0;
        cnt_d         = '0;
        frame_count_d = seq_next;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q        <= RATE_RESET;
      sum_q         <= '0;
      cnt_q         <= '0;
      frame_count_q <= '0;
    end else begin
      rate_q        <= rate_d;
      sum_q         <= sum_d;
      cnt_q         <= cnt_d;
      frame_count_q <= frame_count_d;
    end
  end

  // The closing word hands the whole group to the sequencer in the same edge.
  assign req.start = accept && group_done;
  assign req.seq   = seq_next;
  assign req.sum   = sum_next;
  assign req.rate  = rate_q;

  asf_frame_seq #(
    .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT)
  ) u_frame_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .busy_o        (busy),
    .frame_valid_o (frame_valid_o),
    .frame_stall_i (frame_stall_i),
    .frame_byte_o  (frame_byte_o),
    .last_o        (last_o)
  );

  assign sample_stall_o = busy;

endmodule

// File: dv/asf_frame_checker.sv
`timescale 1ns / 1ps
// Checker of the averaged sample ASCII framer: watches the sample, frame and register
// channels, predicts every frame and compares it character by character.
// Depends on asf_pkg for widths and register constants.
module asf_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  input  logic                         sample_stall_i,
  input  logic [asf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         frame_valid_i,
  input  logic                         frame_stall_i,
  input  logic [asf_pkg::CHAR_W-1:0]   frame_byte_i,
  input  logic                         last_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [asf_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [asf_pkg::DATA_W-1:0]   pwdata_i,
  input  logic [asf_pkg::DATA_W-1:0]   prdata_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           chars_checked_o
);
  import asf_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } frame_char_t;

  frame_char_t       frame_char_q[$];
  frame_char_t       head;
  logic [SUM_W-1:0]  group_sum;
  int                group_fill;
  logic [NUM_W-1:0]  seq_num;
  logic [RATE_W-1:0] rate_reg;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    chars_checked_o = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count_o < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    fail_count_o++;
  endtask

  function automatic logic [CHAR_W-1:0] nibble_to_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? (CHAR_W'("0") + CHAR_W'(nib))
                         : (CHAR_W'("A") + CHAR_W'(nib) - CHAR_W'(10));
  endfunction

  task automatic push_char(input logic [CHAR_W-1:0] c, input logic is_last);
    frame_char_q.push_back('{ch: c, is_last: is_last});
  endtask

  // A closed group yields "$IR,<seq>,<avg>,<rate>*HH" and a newline; the checksum
  // covers everything strictly between the dollar sign and the star.
  task automatic predict_frame(input logic [SUM_W-1:0] sum);
    string             body;
    logic [CHAR_W-1:0] csum;
    logic [SUM_W-1:0]  avg;
    avg = sum / OVERSAMPLE_COUNT_DEF;
    seq_num = seq_num + 1'b1;
    body = $sformatf("IR,%0d,%0d,%0d", seq_num, avg, rate_reg);
    csum = '0;
    push_char("$", 1'b0);
    for (int i = 0; i < body.len(); i++) begin
      csum ^= body[i];
      push_char(body[i], 1'b0);
    end
    push_char("*", 1'b0);
    push_char(nibble_to_ascii(csum[7:4]), 1'b0);
    push_char(nibble_to_ascii(csum[3:0]), 1'b0);
    push_char(CHAR_NL, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_char_q.delete();
      group_sum = '0;
      group_fill = 0;
      seq_num = '0;
      rate_reg = RATE_RESET;
    end else begin
      if (frame_valid_i && !frame_stall_i) begin
        if (frame_char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
                                    frame_byte_i, last_i));
        end else begin
          head = frame_char_q.pop_front();
          chars_checked_o++;
          if (frame_byte_i !== head.ch) begin
            report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h",
                                      frame_byte_i, head.ch));
          end
          if (last_i !== head.is_last) begin
            report_mismatch($sformatf("last=%0b on 8'h%02h, expected %0b",
                                      last_i, frame_byte_i, head.is_last));
          end
        end
      end

      if (sample_valid_i && !sample_stall_i) begin
        group_sum = group_sum + (sample_i & SAMPLE_MASK);
        group_fill++;
        if (group_fill == OVERSAMPLE_COUNT_DEF) begin
          predict_frame(group_sum);
          group_sum = '0;
          group_fill = 0;
        end
      end

      // Only the rate register is mapped; writes elsewhere and out-of-range values
      // leave it alone.
      if (psel_i && penable_i && pready_i && paddr_i[ADDR_W-1:2] == '0
          && paddr_i[2] == REG_RATE) begin
        if (pwrite_i) begin
          if (pwdata_i[RATE_W-1:0] >= RATE_MIN && pwdata_i[RATE_W-1:0] <= RATE_MAX) begin
            rate_reg = pwdata_i[RATE_W-1:0];
          end
        end else if (prdata_i !== DATA_W'(rate_reg)) begin
          report_mismatch($sformatf("rate read 0x%08h, expected 0x%08h",
                                    prdata_i, DATA_W'(rate_reg)));
        end
      end
    end
    pending_o = frame_char_q.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Top of the averaged sample ASCII framer testbench: clock, reset, sample and register
// stimulus and the verdict. Depends on asf_pkg, asf_frame_checker and the core.
module tb;
  import asf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  // Generous wait after the last expected character.
  localparam int SETTLE_CYCLES = 300;
  localparam int RESET_CYCLES = 12;
  localparam logic [ADDR_W-1:0] ADDR_RATE  = {REG_RATE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = {~REG_RATE, 2'b00};
  localparam logic ACC_WRITE = 1'b1;
  localparam logic ACC_READ  = 1'b0;

  typedef enum int {
    GRP_UNIFORM,
    GRP_ZERO,
    GRP_FULL,
    GRP_LOW,
    GRP_ONEHOT
  } group_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                sample_valid_i = 1'b0;
  logic                sample_stall_o;
  logic [SAMPLE_W-1:0] sample_i = '0;
  logic                frame_valid_o;
  logic                frame_stall_i = 1'b0;
  logic [CHAR_W-1:0]   frame_byte_o;
  logic                last_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int          fail_count;
  int          chars_pending;
  int          chars_checked;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          samples_sent = 0;
  int          cycle_count = 0;
  group_mode_e group_mode = GRP_UNIFORM;

  averaged_sample_ascii_framer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .frame_valid_o  (frame_valid_o),
    .frame_stall_i  (frame_stall_i),
    .frame_byte_o   (frame_byte_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  asf_frame_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_stall_i  (sample_stall_o),
    .sample_i        (sample_i),
    .frame_valid_i   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_byte_i    (frame_byte_o),
    .last_i          (last_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .fail_count_o    (fail_count),
    .pending_o       (chars_pending),
    .chars_checked_o (chars_checked)
  );

  // 4 ns clock period.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Safety net: a run that hangs is a failed run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.",
               cycle_count, chars_pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The frame receiver stalls at random, with a fresh decision on every falling edge,
  // so stalls land on every character of the frame and on every sequencer step.
  always @(negedge clk_i) begin
    frame_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // One register access: a setup cycle, then the access cycle held until pready.
  // The bus is released on a falling edge of its own, so back-to-back accesses never
  // assign the same signal twice at one instant.
  task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offers one sample word, possibly after a random gap, and returns on the falling
  // edge after it was taken. Valid stays high on return; the caller lowers it when
  // the stream pauses.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= value;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input group_mode_e mode);
    logic [SAMPLE_W-1:0] v;
    case (mode)
      GRP_ZERO:   v = '0;
      GRP_FULL:   v = SAMPLE_MASK;
      GRP_LOW:    v = SAMPLE_W'($urandom_range(20));
      GRP_ONEHOT: v = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
      default:    v = SAMPLE_W'($urandom_range(4095));
    endcase
    return v;
  endfunction

  // Random samples, with a flavour chosen per group of OVERSAMPLE_COUNT words so
  // that averages reach zero, full scale, truncated small values and single bits
  // as well as the general case. The third group is always all zero, which gives
  // the one-digit average of nought.
  task automatic send_random(input int count);
    repeat (count) begin
      if (samples_sent % OVERSAMPLE_COUNT_DEF == 0) begin
        if (samples_sent / OVERSAMPLE_COUNT_DEF == 2) begin
          group_mode = GRP_ZERO;
        end else begin
          group_mode = group_mode_e'($urandom_range(GRP_ONEHOT));
        end
      end
      send_sample(pick_sample(group_mode));
    end
  endtask

  // Stops the sample stream and lets the block finish, so that the register can be
  // rewritten with nothing in flight.
  task automatic drain();
    sample_valid_i <= 1'b0;
    @(negedge clk_i);
    while (chars_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // First phase: a slow sender and a receiver that stalls most of the time.
    // The rate register is read at its reset value, set to its minimum, and a
    // write of zero must be refused.
    sender_idle_pct = 35;
    receiver_idle_pct = 82;
    reg_access(ACC_READ, ADDR_RATE, '0);
    reg_access(ACC_WRITE, ADDR_RATE, DATA_W'(RATE_MIN));
    reg_access(ACC_WRITE, ADDR_RATE, '0);
    reg_access(ACC_READ, ADDR_RATE, '0);

    // Directed words: a full-scale group gives the widest average, then
    // alternating bit patterns start the next group.
    repeat (OVERSAMPLE_COUNT_DEF) send_sample(SAMPLE_MASK);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0] ? 12'h555 : 12'hAAA);
    end
    send_random(95);
    drain();

    // Second phase: roles swapped. The rate goes to its maximum; values just above
    // it and all ones are refused, and a write to the unmapped address is dropped.
    sender_idle_pct = 82;
    receiver_idle_pct = 35;
    reg_access(ACC_WRITE, ADDR_RATE, DATA_W'(RATE_MAX));
    reg_access(ACC_WRITE, ADDR_RATE, DATA_W'(201));
    reg_access(ACC_WRITE, ADDR_RATE, DATA_W'(255));
    reg_access(ACC_WRITE, ADDR_SPARE, DATA_W'(7));
    reg_access(ACC_READ, ADDR_RATE, '0);
    send_random(95);
    drain();

    // Third phase: full speed on both sides. Only the low byte of the write counts,
    // so set upper bits must not disturb the value 55.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    reg_access(ACC_WRITE, ADDR_RATE, 32'hFFFF_FF37);
    reg_access(ACC_READ, ADDR_RATE, '0);
    // This brings the count to a whole number of groups, so a frame has just
    // been closed; the sender then holds off until every character of it is out.
    send_random(42);
    sample_valid_i <= 1'b0;
    @(negedge clk_i);
    while (chars_pending != 0) @(negedge clk_i);
    send_random(54);
    drain();

    $display("Run covered %0d samples and %0d frame characters over three stall mixes,",
             samples_sent, chars_checked);
    $display("with rates 20, 1, 200 and 55 and refused or unmapped register writes.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: averaged_sample_ascii_framer_core.f
sv/asf_pkg.sv
sv/asf_cmp_sub.sv
sv/asf_frame_seq.sv
sv/averaged_sample_ascii_framer_core.sv
dv/asf_frame_checker.sv
dv/tb.sv
